>>> sv/bii_pkg.sv
package bii_pkg;

  localparam int MAX_BREAKPOINTS_DEF = 64;

  localparam int TICK_W   = 31;
  localparam int IVAL_W   = 8;
  localparam int ENTRY_W  = TICK_W + IVAL_W + 1;
  localparam int MAG_W    = TICK_W;
  localparam int DY_W     = IVAL_W;
  localparam int PROD_W   = MAG_W + DY_W;
  localparam int NUM_W    = PROD_W + 10;
  localparam int REM_W    = TICK_W + 1;
  localparam int BITCNT_W = 6;
  localparam int Q8_W     = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_WR,
    S_WALK,
    S_WALK_CHK,
    S_PREV,
    S_PREV_CHK,
    S_NEXT_CHK,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

endpackage

>>> sv/breakpoint_interval_interpolator.sv
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+---------------------------
// request  | in_operation in_position_tick in_has_interval | start, taken when !busy
//          | in_interval_semitones                         |
// result   | out_status out_has_value out_semitones_q8     | out_valid, one-cycle strobe
//
// clear, append, unknown operation and query on an empty table: result the next cycle;
// an append that needs the tick-0 null entry writes it first and then the new entry
// (one table write port). query: the cursor walks the breakpoints on the registered
// table read, then the serial divider runs.
// synchronous active-low reset empties the table and homes the cursor; the table itself
// is not cleared. results cannot be stalled; a new request may be taken while one shows.
module breakpoint_interval_interpolator
  import bii_pkg::*;
#(
  parameter int MAX_BREAKPOINTS = MAX_BREAKPOINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic [TICK_W-1:0]       in_position_tick,
  input  logic                    in_has_interval,
  input  logic signed [IVAL_W-1:0] in_interval_semitones,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic                    out_has_value,
  output logic signed [Q8_W-1:0]  out_semitones_q8
);

  localparam int AW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int CW = $clog2(MAX_BREAKPOINTS + 1);
  localparam logic [CW:0] MAX_V = (CW+1)'(MAX_BREAKPOINTS);

  // table: {present, interval, tick}
  logic [ENTRY_W-1:0] mem [MAX_BREAKPOINTS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        cursor_r, cursor_nxt;
  logic [CW-1:0]        c_r, c_nxt;
  logic [TICK_W-1:0]    qtick_r, qtick_nxt;
  logic [IVAL_W-1:0]    wr_ival_r, wr_ival_nxt;
  logic                 wr_has_r, wr_has_nxt;
  logic [TICK_W-1:0]    x0_r, x0_nxt;
  logic [IVAL_W-1:0]    y0_r, y0_nxt;
  logic [MAG_W-1:0]     magoff_r, magoff_nxt;
  logic [DY_W-1:0]      magdy_r, magdy_nxt;
  logic [MAG_W-1:0]     d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [BITCNT_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_has_value_r, out_has_value_nxt;
  logic [Q8_W-1:0]      out_q8_r, out_q8_nxt;

  logic [TICK_W-1:0] rd_tick;
  logic [IVAL_W-1:0] rd_ival;
  logic              rd_pres;

  assign rd_tick = rd_data_r[TICK_W-1:0];
  assign rd_ival = rd_data_r[TICK_W+IVAL_W-1:TICK_W];
  assign rd_pres = rd_data_r[ENTRY_W-1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r             <= c_nxt;
    qtick_r         <= qtick_nxt;
    wr_ival_r       <= wr_ival_nxt;
    wr_has_r        <= wr_has_nxt;
    x0_r            <= x0_nxt;
    y0_r            <= y0_nxt;
    magoff_r        <= magoff_nxt;
    magdy_r         <= magdy_nxt;
    d_r             <= d_nxt;
    neg_r           <= neg_nxt;
    num_r           <= num_nxt;
    rem_r           <= rem_nxt;
    bitcnt_r        <= bitcnt_nxt;
    out_status_r    <= out_status_nxt;
    out_has_value_r <= out_has_value_nxt;
    out_q8_r        <= out_q8_nxt;
  end

  logic                 lead;
  logic [CW:0]          need_sum;
  logic signed [TICK_W:0] off_s, dx_s;
  logic signed [IVAL_W:0] dy_s;
  logic [TICK_W:0]      off_abs, dx_abs;
  logic [IVAL_W:0]      dy_abs;
  logic [PROD_W-1:0]    prod;
  logic [REM_W:0]       rem_sh, dvsr;
  logic                 ge;
  logic [REM_W:0]       rem_sub;
  logic signed [18:0]   base, qq, sum;
  logic [Q8_W-1:0]      hold_q8;

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    cursor_nxt        = cursor_r;
    c_nxt             = c_r;
    qtick_nxt         = qtick_r;
    wr_ival_nxt       = wr_ival_r;
    wr_has_nxt        = wr_has_r;
    x0_nxt            = x0_r;
    y0_nxt            = y0_r;
    magoff_nxt        = magoff_r;
    magdy_nxt         = magdy_r;
    d_nxt             = d_r;
    neg_nxt           = neg_r;
    num_nxt           = num_r;
    rem_nxt           = rem_r;
    bitcnt_nxt        = bitcnt_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_has_value_nxt = out_has_value_r;
    out_q8_nxt        = out_q8_r;
    mem_we            = 1'b0;
    mem_addr          = c_r[AW-1:0];
    mem_wdata         = '0;

    lead     = (count_r == '0) && (in_position_tick != '0);
    need_sum = {1'b0, count_r} + (lead ? (CW+1)'(2) : (CW+1)'(1));
    off_s    = $signed({1'b0, qtick_r}) - $signed({1'b0, x0_r});
    dx_s     = $signed({1'b0, rd_tick}) - $signed({1'b0, x0_r});
    dy_s     = $signed({rd_ival[IVAL_W-1], rd_ival}) - $signed({y0_r[IVAL_W-1], y0_r});
    off_abs  = off_s[TICK_W] ? (TICK_W+1)'(-off_s) : off_s;
    dx_abs   = dx_s[TICK_W] ? (TICK_W+1)'(-dx_s) : dx_s;
    dy_abs   = dy_s[IVAL_W] ? (IVAL_W+1)'(-dy_s) : dy_s;
    prod     = magoff_r * magdy_r;
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    dvsr     = {1'b0, d_r, 1'b0};
    ge       = (rem_sh >= dvsr);
    rem_sub  = rem_sh - dvsr;
    hold_q8  = {y0_r, 8'd0};
    base     = {{3{y0_r[IVAL_W-1]}}, y0_r, 8'd0};
    qq       = {2'b00, num_r[16:0]};
    sum      = neg_r ? (base - qq) : (base + qq);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_status_nxt    = ST_OK;
          out_has_value_nxt = 1'b0;
          out_q8_nxt        = '0;
          case (in_operation)
            OP_CLEAR: begin
              count_nxt     = '0;
              cursor_nxt    = '0;
              out_valid_nxt = 1'b1;
            end
            OP_APPEND: begin
              if (need_sum > MAX_V) begin
                out_status_nxt = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else if (lead) begin
                // null breakpoint at tick 0 first, the new entry next cycle
                mem_we      = 1'b1;
                mem_addr    = '0;
                mem_wdata   = '0;
                count_nxt   = CW'(1);
                qtick_nxt   = in_position_tick;
                wr_ival_nxt = in_interval_semitones;
                wr_has_nxt  = in_has_interval;
                state_nxt   = S_APP_WR;
              end else begin
                mem_we        = 1'b1;
                mem_addr      = count_r[AW-1:0];
                mem_wdata     = {in_has_interval,
                                 in_has_interval ? in_interval_semitones : '0,
                                 in_position_tick};
                count_nxt     = count_r + CW'(1);
                out_valid_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                qtick_nxt = in_position_tick;
                c_nxt     = (cursor_r > count_r) ? count_r : cursor_r;
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_APP_WR: begin
        mem_we        = 1'b1;
        mem_addr      = count_r[AW-1:0];
        mem_wdata     = {wr_has_r, wr_has_r ? wr_ival_r : '0, qtick_r};
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (c_r < count_r) begin
          mem_addr  = c_r[AW-1:0];
          state_nxt = S_WALK_CHK;
        end else begin
          state_nxt = S_PREV;
        end
      end
      S_WALK_CHK: begin
        if (rd_tick <= qtick_r) begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_PREV;
        end
      end
      S_PREV: begin
        cursor_nxt = c_r;
        if (c_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_addr  = AW'(c_r - CW'(1));
          state_nxt = S_PREV_CHK;
        end
      end
      S_PREV_CHK: begin
        x0_nxt = rd_tick;
        y0_nxt = rd_ival;
        if (!rd_pres) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (c_r == count_r) begin
          out_has_value_nxt = 1'b1;
          out_q8_nxt        = {rd_ival, 8'd0};
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          mem_addr  = c_r[AW-1:0];
          state_nxt = S_NEXT_CHK;
        end
      end
      S_NEXT_CHK: begin
        if (!rd_pres || (rd_tick == x0_r)) begin
          out_has_value_nxt = 1'b1;
          out_q8_nxt        = hold_q8;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          magoff_nxt = off_abs[MAG_W-1:0];
          magdy_nxt  = dy_abs[DY_W-1:0];
          d_nxt      = dx_abs[MAG_W-1:0];
          neg_nxt    = off_s[TICK_W] ^ dy_s[IVAL_W] ^ dx_s[TICK_W];
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        // dividend 2*|off*dy*256| + |dx|, divisor 2*|dx|: rounds half away from zero
        num_nxt    = {1'b0, prod, 9'd0} + NUM_W'(d_r);
        rem_nxt    = '0;
        bitcnt_nxt = BITCNT_W'(NUM_W - 1);
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], ge};
        if (bitcnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          bitcnt_nxt = bitcnt_r - BITCNT_W'(1);
        end
      end
      S_FIN: begin
        out_has_value_nxt = 1'b1;
        if (|num_r[NUM_W-1:17]) begin
          out_q8_nxt = neg_r ? 16'h8000 : 16'h7FFF;
        end else if (sum > 19'sd32767) begin
          out_q8_nxt = 16'h7FFF;
        end else if (sum < -19'sd32768) begin
          out_q8_nxt = 16'h8000;
        end else begin
          out_q8_nxt = sum[Q8_W-1:0];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_has_value    = out_has_value_r;
  assign out_semitones_q8 = out_q8_r;

`ifndef SYNTHESIS
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while sequencer busy");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond table fill");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= MAX_V)
    else $error("table fill exceeds depth");

  a_query_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_QUERY && count_r != '0) |=> busy)
    else $error("query on filled table did not start sequencer");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_CLEAR) |=>
      (count_r == '0 && cursor_r == '0 && out_valid && out_status == ST_OK))
    else $error("clear did not empty table in one cycle");
`endif

endmodule
